### rtl/bba_pkg.sv
// types, constants and microcode table for the buddy block allocator
// no dependencies; used by bba_seq, buddy_block_allocator and the testbench
package bba_pkg;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_NOTALLOC = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        RA_ROOT   = 3'd0,
        RA_LEFT   = 3'd1,
        RA_LEAF   = 3'd2,
        RA_PARENT = 3'd3,
        RA_SIB    = 3'd4
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE  = 3'd0,
        WR_INIT  = 3'd1,
        WR_ZERO  = 3'd2,
        WR_SPAN  = 3'd3,
        WR_MERGE = 3'd4
    } wr_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD   = 3'd0,
        IDX_ZERO   = 3'd1,
        IDX_INC    = 3'd2,
        IDX_LEAF   = 3'd3,
        IDX_PARENT = 3'd4,
        IDX_DESC   = 3'd5
    } idx_sel_t;

    typedef enum logic [2:0] {
        SP_HOLD   = 3'd0,
        SP_UNITS  = 3'd1,
        SP_ONE    = 3'd2,
        SP_HALF   = 3'd3,
        SP_DOUBLE = 3'd4,
        SP_INIT   = 3'd5
    } span_sel_t;

    typedef enum logic [3:0] {
        COND_NEVER        = 4'd0,
        COND_ALWAYS       = 4'd1,
        COND_INIT_MORE    = 4'd2,
        COND_NO_IN        = 4'd3,
        COND_CMD_ALLOC    = 4'd4,
        COND_CMD_NONE     = 4'd5,
        COND_CMD_QUERY    = 4'd6,
        COND_OFF_RANGE    = 4'd7,
        COND_RD_ZERO      = 4'd8,
        COND_RD_LT_WANT   = 4'd9,
        COND_SPAN_LE_WANT = 4'd10,
        COND_IDX_ROOT     = 4'd11,
        COND_IDX_NOT_ROOT = 4'd12,
        COND_OUT_FREE     = 4'd13
    } cond_t;

    typedef logic [4:0] step_t;

    localparam step_t STEP_INIT     = 5'd0;
    localparam step_t STEP_IDLE     = 5'd1;
    localparam step_t STEP_DISP     = 5'd2;
    localparam step_t STEP_DISP2    = 5'd3;
    localparam step_t STEP_F0       = 5'd4;
    localparam step_t STEP_F1       = 5'd5;
    localparam step_t STEP_F2       = 5'd6;
    localparam step_t STEP_NOTALLOC = 5'd7;
    localparam step_t STEP_FOUND    = 5'd8;
    localparam step_t STEP_FREE_W   = 5'd9;
    localparam step_t STEP_U0       = 5'd10;
    localparam step_t STEP_U1       = 5'd11;
    localparam step_t STEP_DONE     = 5'd12;
    localparam step_t STEP_DONE_W   = 5'd13;
    localparam step_t STEP_A0       = 5'd14;
    localparam step_t STEP_A1       = 5'd15;
    localparam step_t STEP_D0       = 5'd16;
    localparam step_t STEP_D1       = 5'd17;
    localparam step_t STEP_MARK     = 5'd18;
    localparam step_t STEP_MARK_END = 5'd19;
    localparam step_t STEP_NOSPACE  = 5'd20;
    localparam step_t STEP_RANGE    = 5'd21;

    typedef struct packed {
        rd_sel_t   rd_sel;
        wr_sel_t   wr_sel;
        idx_sel_t  idx_sel;
        span_sel_t span_sel;
        logic      stat_en;
        status_t   stat_code;
        logic      bsz_en;
        logic      accept;
        logic      emit;
        cond_t     cond;
        step_t     target;
    } ucode_t;

    typedef struct packed {
        logic init_more;
        logic no_in;
        logic cmd_alloc;
        logic cmd_none;
        logic cmd_query;
        logic off_range;
        logic rd_zero;
        logic rd_lt_want;
        logic span_le_want;
        logic idx_root;
        logic out_free;
    } flags_t;

    localparam ucode_t UCODE_NOP = '{
        rd_sel:    RA_ROOT,
        wr_sel:    WR_NONE,
        idx_sel:   IDX_HOLD,
        span_sel:  SP_HOLD,
        stat_en:   1'b0,
        stat_code: ST_OK,
        bsz_en:    1'b0,
        accept:    1'b0,
        emit:      1'b0,
        cond:      COND_NEVER,
        target:    STEP_INIT
    };

    function automatic ucode_t ucode_word(input step_t step);
        ucode_t w;
        w = UCODE_NOP;
        unique case (step)
            STEP_INIT:
            begin
                w.wr_sel   = WR_INIT;
                w.idx_sel  = IDX_INC;
                w.span_sel = SP_INIT;
                w.cond     = COND_INIT_MORE;
                w.target   = STEP_INIT;
            end
            STEP_IDLE:
            begin
                w.accept = 1'b1;
                w.cond   = COND_NO_IN;
                w.target = STEP_IDLE;
            end
            STEP_DISP:
            begin
                w.cond   = COND_CMD_ALLOC;
                w.target = STEP_A0;
            end
            STEP_DISP2:
            begin
                w.cond   = COND_CMD_NONE;
                w.target = STEP_DONE;
            end
            STEP_F0:
            begin
                w.rd_sel   = RA_LEAF;
                w.idx_sel  = IDX_LEAF;
                w.span_sel = SP_ONE;
                w.cond     = COND_OFF_RANGE;
                w.target   = STEP_RANGE;
            end
            STEP_F1:
            begin
                w.cond   = COND_RD_ZERO;
                w.target = STEP_FOUND;
            end
            STEP_F2:
            begin
                w.rd_sel   = RA_PARENT;
                w.idx_sel  = IDX_PARENT;
                w.span_sel = SP_DOUBLE;
                w.cond     = COND_IDX_NOT_ROOT;
                w.target   = STEP_F1;
            end
            STEP_NOTALLOC:
            begin
                w.stat_en   = 1'b1;
                w.stat_code = ST_NOTALLOC;
                w.cond      = COND_ALWAYS;
                w.target    = STEP_DONE;
            end
            STEP_FOUND:
            begin
                w.bsz_en = 1'b1;
                w.cond   = COND_CMD_QUERY;
                w.target = STEP_DONE;
            end
            STEP_FREE_W:
            begin
                w.wr_sel = WR_SPAN;
                w.cond   = COND_IDX_ROOT;
                w.target = STEP_DONE;
            end
            STEP_U0:
            begin
                w.rd_sel   = RA_SIB;
                w.idx_sel  = IDX_PARENT;
                w.span_sel = SP_DOUBLE;
            end
            STEP_U1:
            begin
                w.wr_sel = WR_MERGE;
                w.cond   = COND_IDX_NOT_ROOT;
                w.target = STEP_U0;
            end
            STEP_DONE:
            begin
                w.emit   = 1'b1;
                w.cond   = COND_OUT_FREE;
                w.target = STEP_IDLE;
            end
            STEP_DONE_W:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_DONE;
            end
            STEP_A0:
            begin
                w.rd_sel   = RA_ROOT;
                w.idx_sel  = IDX_ZERO;
                w.span_sel = SP_UNITS;
            end
            STEP_A1:
            begin
                w.cond   = COND_RD_LT_WANT;
                w.target = STEP_NOSPACE;
            end
            STEP_D0:
            begin
                w.rd_sel = RA_LEFT;
                w.cond   = COND_SPAN_LE_WANT;
                w.target = STEP_MARK;
            end
            STEP_D1:
            begin
                w.idx_sel  = IDX_DESC;
                w.span_sel = SP_HALF;
                w.cond     = COND_ALWAYS;
                w.target   = STEP_D0;
            end
            STEP_MARK:
            begin
                w.wr_sel = WR_ZERO;
                w.bsz_en = 1'b1;
                w.cond   = COND_IDX_NOT_ROOT;
                w.target = STEP_U0;
            end
            STEP_MARK_END:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_DONE;
            end
            STEP_NOSPACE:
            begin
                w.stat_en   = 1'b1;
                w.stat_code = ST_NOSPACE;
                w.cond      = COND_ALWAYS;
                w.target    = STEP_DONE;
            end
            STEP_RANGE:
            begin
                w.stat_en   = 1'b1;
                w.stat_code = ST_RANGE;
                w.cond      = COND_ALWAYS;
                w.target    = STEP_DONE;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    // smallest power of two not below the request, zero counts as one
    function automatic logic [8:0] round_pow2(input logic [7:0] n);
        logic [8:0] p;
        logic [8:0] m;
        p = 9'd1;
        m = (n == 8'd0) ? 9'd1 : {1'b0, n};
        for (int i = 0; i < 8; i++) begin
            if (p < m) begin
                p = p << 1;
            end
        end
        return p;
    endfunction

endpackage

### rtl/bba_ram.sv
// generic single write, single read port ram with registered read data
// no dependencies
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/bba_seq.sv
// microcode sequencer: step counter, control word table and conditional jumps
// depends on bba_pkg
module bba_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  bba_pkg::flags_t flags,
    output bba_pkg::ucode_t ctl
);

    bba_pkg::step_t step_reg;
    bba_pkg::step_t step_next;
    logic           take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= bba_pkg::STEP_INIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        ctl = bba_pkg::ucode_word(step_reg);
        unique case (ctl.cond)
            bba_pkg::COND_NEVER:        take = 1'b0;
            bba_pkg::COND_ALWAYS:       take = 1'b1;
            bba_pkg::COND_INIT_MORE:    take = flags.init_more;
            bba_pkg::COND_NO_IN:        take = flags.no_in;
            bba_pkg::COND_CMD_ALLOC:    take = flags.cmd_alloc;
            bba_pkg::COND_CMD_NONE:     take = flags.cmd_none;
            bba_pkg::COND_CMD_QUERY:    take = flags.cmd_query;
            bba_pkg::COND_OFF_RANGE:    take = flags.off_range;
            bba_pkg::COND_RD_ZERO:      take = flags.rd_zero;
            bba_pkg::COND_RD_LT_WANT:   take = flags.rd_lt_want;
            bba_pkg::COND_SPAN_LE_WANT: take = flags.span_le_want;
            bba_pkg::COND_IDX_ROOT:     take = flags.idx_root;
            bba_pkg::COND_IDX_NOT_ROOT: take = !flags.idx_root;
            bba_pkg::COND_OUT_FREE:     take = flags.out_free;
            default:                    take = 1'b0;
        endcase
        step_next = take ? ctl.target : step_reg + 5'd1;
    end

endmodule

### rtl/buddy_block_allocator.sv
// binary buddy allocator: largest-free-run tree in ram, walked by a microcode sequencer
// allocate: descend from the root to a fitting block, then refresh its ancestors
// free and query: climb from the leaf; the idle step comes before the next transfer
// a finished result waits in the output register while the next item is taken
// after reset a fill pass marks all 2*UNITS-1 nodes free, in_ready stays low meanwhile
// depends on bba_pkg, bba_seq, bba_ram
module buddy_block_allocator #(
    parameter int UNITS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] cmd,
    input  logic [7:0] req_size,
    input  logic [5:0] offset,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [5:0] alloc_offset,
    output logic [6:0] block_size
);

    localparam int NODES = 2 * UNITS - 1;
    localparam int NW    = $clog2(NODES);
    localparam int AW    = $clog2(UNITS);
    localparam int VW    = AW + 1;
    localparam int CW    = (VW > 9) ? VW : 9;
    localparam int LW    = ((NW > 6) ? NW : 6) + 1;

    bba_pkg::ucode_t ctl;
    bba_pkg::flags_t flags;

    // sequencing state
    logic [NW-1:0]    idx_reg;
    logic [NW-1:0]    idx_next;
    logic [VW-1:0]    span_reg;
    logic [VW-1:0]    span_next;
    logic             out_valid_reg;

    // per item working registers
    bba_pkg::cmd_t    cmd_reg;
    logic [8:0]       want_reg;
    logic [5:0]       off_reg;
    logic [AW-1:0]    start_reg;
    logic [VW-1:0]    cur_reg;
    logic [VW-1:0]    bsize_reg;
    bba_pkg::status_t status_reg;

    // result register
    bba_pkg::status_t out_status_reg;
    logic [5:0]       out_offset_reg;
    logic [6:0]       out_size_reg;

    logic             in_fire;
    logic             out_free;
    logic             wr_en;
    logic [VW-1:0]    wr_data;
    logic [NW-1:0]    rd_addr;
    logic [VW-1:0]    rd_data;

    logic [NW-1:0]    left;
    logic [NW-1:0]    idx_m1;
    logic [NW-1:0]    parent;
    logic [NW-1:0]    sib;
    logic [LW-1:0]    leaf_wide;
    logic [NW-1:0]    leaf;
    logic [NW:0]      idx_inc;
    logic             level_end;
    logic             rd_ge_want;
    logic [VW:0]      pair_sum;
    logic [VW-1:0]    merge_val;
    logic [AW+5:0]    start_wide;
    logic [VW+6:0]    size_wide;

    bba_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctl   (ctl)
    );

    bba_ram #(
        .WIDTH (VW),
        .DEPTH (NODES)
    ) u_tree (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready  = ctl.accept;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // tree navigation
    assign left      = {idx_reg[NW-2:0], 1'b1};
    assign idx_m1    = idx_reg - NW'(1);
    assign parent    = {1'b0, idx_m1[NW-1:1]};
    assign sib       = idx_reg[0] ? idx_reg + NW'(1) : idx_m1;
    assign leaf_wide = LW'(off_reg) + LW'(UNITS - 1);
    assign leaf      = leaf_wide[NW-1:0];
    assign idx_inc   = {1'b0, idx_reg} + (NW + 1)'(1);
    assign level_end = ((idx_inc + (NW + 1)'(1)) & idx_inc) == '0;

    assign rd_ge_want = CW'(rd_data) >= CW'(want_reg);

    // buddies that are both whole merge back into the parent's span
    assign pair_sum  = {1'b0, cur_reg} + {1'b0, rd_data};
    assign merge_val = (pair_sum == {1'b0, span_reg}) ? span_reg
                     : ((cur_reg > rd_data) ? cur_reg : rd_data);

    assign flags.init_more    = idx_reg != NW'(NODES - 1);
    assign flags.no_in        = !in_valid;
    assign flags.cmd_alloc    = cmd_reg == bba_pkg::CMD_ALLOC;
    assign flags.cmd_none     = cmd_reg == bba_pkg::CMD_NONE;
    assign flags.cmd_query    = cmd_reg == bba_pkg::CMD_QUERY;
    assign flags.off_range    = LW'(off_reg) >= LW'(UNITS);
    assign flags.rd_zero      = rd_data == '0;
    assign flags.rd_lt_want   = !rd_ge_want;
    assign flags.span_le_want = CW'(span_reg) <= CW'(want_reg);
    assign flags.idx_root     = idx_reg == '0;
    assign flags.out_free     = out_free;

    always_comb
    begin
        unique case (ctl.rd_sel)
            bba_pkg::RA_ROOT:   rd_addr = '0;
            bba_pkg::RA_LEFT:   rd_addr = left;
            bba_pkg::RA_LEAF:   rd_addr = leaf;
            bba_pkg::RA_PARENT: rd_addr = parent;
            bba_pkg::RA_SIB:    rd_addr = sib;
            default:            rd_addr = '0;
        endcase

        wr_en = ctl.wr_sel != bba_pkg::WR_NONE;
        unique case (ctl.wr_sel)
            bba_pkg::WR_INIT:  wr_data = span_reg;
            bba_pkg::WR_ZERO:  wr_data = '0;
            bba_pkg::WR_SPAN:  wr_data = span_reg;
            bba_pkg::WR_MERGE: wr_data = merge_val;
            default:           wr_data = '0;
        endcase

        unique case (ctl.idx_sel)
            bba_pkg::IDX_HOLD:   idx_next = idx_reg;
            bba_pkg::IDX_ZERO:   idx_next = '0;
            bba_pkg::IDX_INC:    idx_next = idx_inc[NW-1:0];
            bba_pkg::IDX_LEAF:   idx_next = leaf;
            bba_pkg::IDX_PARENT: idx_next = parent;
            bba_pkg::IDX_DESC:   idx_next = rd_ge_want ? left : left + NW'(1);
            default:             idx_next = idx_reg;
        endcase

        unique case (ctl.span_sel)
            bba_pkg::SP_HOLD:   span_next = span_reg;
            bba_pkg::SP_UNITS:  span_next = VW'(UNITS);
            bba_pkg::SP_ONE:    span_next = VW'(1);
            bba_pkg::SP_HALF:   span_next = span_reg >> 1;
            bba_pkg::SP_DOUBLE: span_next = span_reg << 1;
            bba_pkg::SP_INIT:   span_next = level_end ? (span_reg >> 1) : span_reg;
            default:            span_next = span_reg;
        endcase

        start_wide = {6'b0, start_reg};
        size_wide  = {7'b0, bsize_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            span_reg      <= VW'(UNITS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            span_reg <= span_next;
            if (ctl.emit && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg    <= bba_pkg::cmd_t'(cmd);
            want_reg   <= bba_pkg::round_pow2(req_size);
            off_reg    <= offset;
            start_reg  <= '0;
            bsize_reg  <= '0;
            status_reg <= bba_pkg::ST_OK;
        end
        else
        begin
            if (ctl.idx_sel == bba_pkg::IDX_DESC && !rd_ge_want)
            begin
                start_reg <= start_reg + span_reg[VW-1:1];
            end
            if (ctl.bsz_en)
            begin
                bsize_reg <= span_reg;
            end
            if (ctl.stat_en)
            begin
                status_reg <= ctl.stat_code;
            end
        end
        if (wr_en)
        begin
            cur_reg <= wr_data;
        end
        if (ctl.emit && out_free)
        begin
            out_status_reg <= status_reg;
            out_offset_reg <= start_wide[5:0];
            out_size_reg   <= size_wide[6:0];
        end
    end

    assign status       = out_status_reg;
    assign alloc_offset = out_offset_reg;
    assign block_size   = out_size_reg;

    // the tree is never written while a new item may be taken
    a_no_write_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !wr_en)
        else $error("tree write while accepting");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("second transfer in while busy");

    // a merged node never exceeds its own span
    a_merge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.wr_sel == bba_pkg::WR_MERGE) |-> (merge_val <= span_reg))
        else $error("merged free run above span");

    // a granted block always has a size
    a_alloc_size: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit && out_free && status_reg == bba_pkg::ST_OK
         && cmd_reg == bba_pkg::CMD_ALLOC) |-> (bsize_reg != '0))
        else $error("ok allocate without block size");

endmodule

### tb/buddy_alloc_checker.sv
// checker for the buddy block allocator: mirrors the free-run tree, predicts every reply
// and compares accepted replies against them in order; depends on bba_pkg
module buddy_alloc_checker #(
    parameter int UNITS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] cmd,
    input  logic [7:0] req_size,
    input  logic [5:0] offset,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] status,
    input  logic [5:0] alloc_offset,
    input  logic [6:0] block_size,
    output int         mismatches,
    output int         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    localparam int NODES = 2 * UNITS - 1;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        status_t    st;
        logic [5:0] start;
        logic [6:0] size;
    } reply_t;

    int     pool_tree [NODES];
    reply_t expected_replies [$];
    reply_t want_reply;
    int     failures;
    int     node_span;

    function automatic reply_t predict_reply(input cmd_t c, input logic [7:0] req,
                                             input logic [5:0] off);
        reply_t r;
        int     want;
        int     node;
        int     span;
        int     lv;
        int     rv;
        r = '{st: ST_OK, start: '0, size: '0};
        case (c)
            CMD_ALLOC:
            begin
                want = 1;
                while (want < int'(req))
                    want = want << 1;
                if (pool_tree[0] < want)
                begin
                    r.st = ST_NOSPACE;
                end
                else
                begin
                    node = 0;
                    span = UNITS;
                    while (span > want)
                    begin
                        node = (pool_tree[2 * node + 1] >= want) ? 2 * node + 1 : 2 * node + 2;
                        span = span >> 1;
                    end
                    pool_tree[node] = 0;
                    r.start = 6'((node + 1) * span - UNITS);
                    r.size  = 7'(span);
                    while (node != 0)
                    begin
                        node = (node - 1) / 2;
                        lv = pool_tree[2 * node + 1];
                        rv = pool_tree[2 * node + 2];
                        pool_tree[node] = (lv > rv) ? lv : rv;
                    end
                end
            end
            CMD_FREE, CMD_QUERY:
            begin
                if (int'(off) >= UNITS)
                begin
                    r.st = ST_RANGE;
                end
                else
                begin
                    node = int'(off) + UNITS - 1;
                    span = 1;
                    while (pool_tree[node] != 0 && node != 0)
                    begin
                        node = (node - 1) / 2;
                        span = span << 1;
                    end
                    if (pool_tree[node] != 0)
                    begin
                        r.st = ST_NOTALLOC;
                    end
                    else
                    begin
                        r.size = 7'(span);
                        if (c == CMD_FREE)
                        begin
                            pool_tree[node] = span;
                            while (node != 0)
                            begin
                                node = (node - 1) / 2;
                                span = span << 1;
                                lv = pool_tree[2 * node + 1];
                                rv = pool_tree[2 * node + 2];
                                pool_tree[node] = (lv + rv == span) ? span : ((lv > rv) ? lv : rv);
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_span = 2 * UNITS;
            for (int i = 0; i < NODES; i++)
            begin
                if (((i + 1) & i) == 0)
                    node_span = node_span >> 1;
                pool_tree[i] = node_span;
            end
            expected_replies.delete();
            failures = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    if (failures < REPORT_LIMIT)
                        $display("%0t unexpected reply: status %0d offset %0d size %0d",
                                 $realtime, status, alloc_offset, block_size);
                    failures++;
                end
                else
                begin
                    want_reply = expected_replies.pop_front();
                    if (status !== want_reply.st || alloc_offset !== want_reply.start ||
                        block_size !== want_reply.size)
                    begin
                        if (failures < REPORT_LIMIT)
                            $display(
                                "%0t mismatch: expected st/off/size %0d/%0d/%0d got %0d/%0d/%0d",
                                $realtime, want_reply.st, want_reply.start,
                                want_reply.size, status, alloc_offset, block_size);
                        failures++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_replies.push_back(predict_reply(cmd_t'(cmd), req_size, offset));
            mismatches  <= failures;
            outstanding <= expected_replies.size();
        end
    end

endmodule

### tb/buddy_block_allocator_test.sv
// top of the buddy block allocator testbench: clock, reset, request stimulus, reply stalls
// and the verdict; depends on bba_pkg, buddy_block_allocator and buddy_alloc_checker
module buddy_block_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    localparam int UNITS = 64;
    localparam int CLK_PERIOD = 8;
    localparam int RANDOM_ITEMS = 950;
    localparam int HOLD_OFF_AT = 300;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 64;
    localparam int IDLE_LIMIT = 4000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] cmd = CMD_NONE;
    logic [7:0] req_size = '0;
    logic [5:0] offset = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] status;
    logic [5:0] alloc_offset;
    logic [6:0] block_size;

    int mismatches;
    int outstanding;
    int requests_sent = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    bit held_off = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    buddy_block_allocator #(
        .UNITS(UNITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .req_size    (req_size),
        .offset      (offset),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .alloc_offset(alloc_offset),
        .block_size  (block_size)
    );

    buddy_alloc_checker #(
        .UNITS(UNITS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .req_size    (req_size),
        .offset      (offset),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .alloc_offset(alloc_offset),
        .block_size  (block_size),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    task automatic send_request(input cmd_t c, input logic [7:0] sz, input logic [5:0] off);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd      <= c;
        req_size <= sz;
        offset   <= off;
        do
            @(posedge clk);
        while (!in_ready);
        requests_sent++;
    endtask

    // reply side stall pattern, with one long hold-off to back up the request side
    initial
    begin
        int mode;
        int stretch;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 2);
            stretch = $urandom_range(20, 80);
            repeat (stretch)
            begin
                @(posedge clk);
                if (!held_off && requests_sent >= HOLD_OFF_AT)
                begin
                    held_off = 1'b1;
                    out_ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                end
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= $urandom_range(0, 1);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int pick;
        logic [7:0] sz;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty pool, whole pool, oversize, inside-block frees, merges
        send_request(CMD_QUERY, 8'd0, 6'd0);
        send_request(CMD_FREE, 8'd0, 6'd63);
        send_request(CMD_ALLOC, 8'd64, 6'd0);
        send_request(CMD_ALLOC, 8'd0, 6'd0);
        send_request(CMD_QUERY, 8'd0, 6'd37);
        send_request(CMD_FREE, 8'd0, 6'd63);
        send_request(CMD_ALLOC, 8'd0, 6'd0);
        send_request(CMD_ALLOC, 8'd1, 6'd0);
        send_request(CMD_ALLOC, 8'd3, 6'd0);
        send_request(CMD_ALLOC, 8'd255, 6'd0);
        send_request(CMD_ALLOC, 8'd128, 6'd0);
        send_request(CMD_ALLOC, 8'd33, 6'd0);
        send_request(CMD_ALLOC, 8'd32, 6'd0);
        send_request(CMD_QUERY, 8'd0, 6'd6);
        send_request(CMD_NONE, 8'd255, 6'd63);
        send_request(CMD_FREE, 8'd0, 6'd5);
        send_request(CMD_FREE, 8'd0, 6'd5);
        send_request(CMD_FREE, 8'd0, 6'd0);
        send_request(CMD_FREE, 8'd0, 6'd1);
        send_request(CMD_FREE, 8'd0, 6'd40);
        send_request(CMD_QUERY, 8'd0, 6'd0);
        send_request(CMD_ALLOC, 8'd16, 6'd0);
        send_request(CMD_ALLOC, 8'd2, 6'd0);
        send_request(CMD_FREE, 8'd255, 6'd21);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 15);
            case (pick)
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: sz = 8'($urandom_range(0, 4));
                10, 11, 12:                   sz = 8'($urandom_range(5, 16));
                13, 14:                       sz = 8'($urandom_range(17, 64));
                default:                      sz = 8'($urandom_range(0, 255));
            endcase
            pick = $urandom_range(0, 19);
            if (pick <= 8)
                send_request(CMD_ALLOC, sz, 6'($urandom_range(0, 63)));
            else if (pick <= 14)
                send_request(CMD_FREE, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
            else if (pick <= 18)
                send_request(CMD_QUERY, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
            else
                send_request(CMD_NONE, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
        end
        in_valid <= 1'b0;

        // let the checker count the last transfer before waiting on it
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
